### hdl/gppag_pkg.sv
// ----------------------------------------------------------------------------
// GEMM panel pack address generator package
// Shared constants for the panel packing address generator: configuration
// register indexes, block widths and counter widths.
// ----------------------------------------------------------------------------
package gppag_pkg;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 3;

  // Width of the column-in-block counter and of a block width.
  localparam int unsigned BLK_W = 3;

  // The packed element counter wraps at 2^32.
  localparam int unsigned COUNT_BITS = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_LENGTH    = 3'd0,
    REG_M_LENGTH    = 3'd1,
    REG_ROW_STRIDE  = 3'd2,
    REG_K_OFFSET    = 3'd3,
    REG_M_OFFSET    = 3'd4,
    REG_BLOCK_MODE  = 3'd5,
    REG_SOURCE_BASE = 3'd6,
    REG_DEST_BASE   = 3'd7
  } cfg_reg_e;

  // Column block widths.
  localparam logic [BLK_W-1:0] BW_ONE  = 3'd1;
  localparam logic [BLK_W-1:0] BW_TWO  = 3'd2;
  localparam logic [BLK_W-1:0] BW_FOUR = 3'd4;
  localparam logic [BLK_W-1:0] BW_SIX  = 3'd6;

endpackage

### hdl/gemm_panel_pack_address_gen_top.sv
// ----------------------------------------------------------------------------
// GEMM panel pack address generator
// Emits one source/destination element address pair per request, walking a
// K-by-M submatrix in column blocks and row pairs to build a packed panel.
// ----------------------------------------------------------------------------
// A request is taken in every cycle while the pipeline has room; each one
// passes the position update, row/column offset, multiply and final add in
// order, so the sustained rate is one address pair per cycle unless the
// output stalls. The input can keep accepting while a finished result waits
// on the output, until all four stages hold an item. A request made while
// k_length or m_length is zero is consumed without a result and leaves the
// walk position unchanged. Restart set begins the walk at the first element;
// clear advances to the next one (the first if the held position no longer
// fits), wrapping to the first after the final element (marked with tlast).
module gemm_panel_pack_address_gen_top
  import gppag_pkg::*;
#(
  parameter int unsigned DIM_BITS  = 16,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Configuration write port.
  input  logic                                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                       cfg_idx_i,
  input  logic [((ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS)-1:0] cfg_data_i,
  // Request stream.
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [7:0]                                 s_axis_tdata,  // [0] restart
  // Result stream.
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // source_address, then dest_address, zero padded to whole bytes
  output logic [((2*ADDR_BITS+7)/8)*8-1:0]           m_axis_tdata,
  output logic                                       m_axis_tlast   // last element
);

  localparam int unsigned OUT_W  = ((2*ADDR_BITS + 7) / 8) * 8;
  localparam int unsigned PROD_W = 2*DIM_BITS + 1;

  // Walk position within the pack.
  typedef struct packed {
    logic [DIM_BITS-1:0]   bfc;  // first column of the current block
    logic [DIM_BITS-1:0]   pfr;  // first row of the current row pair
    logic [BLK_W-1:0]      cib;  // column within the block
    logic                  rip;  // row within the pair
    logic [COUNT_BITS-1:0] dc;   // packed element index
  } pos_t;

  // Width of the block that starts with rem columns still to pack.
  function automatic logic [BLK_W-1:0] width_for(input logic mode,
                                                  input logic [DIM_BITS-1:0] rem);
    logic [BLK_W-1:0] w;
    if (mode && (rem >= DIM_BITS'(BW_SIX))) begin
      w = BW_SIX;
    end else if (rem >= DIM_BITS'(BW_FOUR)) begin
      w = BW_FOUR;
    end else if (rem >= DIM_BITS'(BW_TWO)) begin
      w = BW_TWO;
    end else begin
      w = BW_ONE;
    end
    return w;
  endfunction

  // Configuration registers.
  logic [DIM_BITS-1:0]  k_len_q, m_len_q, stride_q, k_off_q, m_off_q;
  logic                 mode_q;
  logic [ADDR_BITS-1:0] src_base_q, dst_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_len_q    <= DIM_BITS'(1);
      m_len_q    <= DIM_BITS'(1);
      stride_q   <= DIM_BITS'(1);
      k_off_q    <= '0;
      m_off_q    <= '0;
      mode_q     <= 1'b0;
      src_base_q <= '0;
      dst_base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_K_LENGTH:    k_len_q    <= cfg_data_i[DIM_BITS-1:0];
        REG_M_LENGTH:    m_len_q    <= cfg_data_i[DIM_BITS-1:0];
        REG_ROW_STRIDE:  stride_q   <= cfg_data_i[DIM_BITS-1:0];
        REG_K_OFFSET:    k_off_q    <= cfg_data_i[DIM_BITS-1:0];
        REG_M_OFFSET:    m_off_q    <= cfg_data_i[DIM_BITS-1:0];
        REG_BLOCK_MODE:  mode_q     <= cfg_data_i[0];
        REG_SOURCE_BASE: src_base_q <= cfg_data_i[ADDR_BITS-1:0];
        REG_DEST_BASE:   dst_base_q <= cfg_data_i[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or moves on.
  logic out_v_q, s3_v_q, s2_v_q, s1_v_q;
  logic rdy_out, rdy3, rdy2, accept, len_ok;

  assign rdy_out       = !out_v_q || m_axis_tready;
  assign rdy3          = !s3_v_q || rdy_out;
  assign rdy2          = !s2_v_q || rdy3;
  assign s_axis_tready = !s1_v_q || rdy2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign len_ok        = (k_len_q != '0) && (m_len_q != '0);

  // Position update: restart, advance, or restart on a stale position.
  pos_t                pos_q, pos_d;
  logic [DIM_BITS-1:0] rem_cur;
  logic [BLK_W-1:0]    bw_cur;
  logic [DIM_BITS:0]   pfr_x, k_x, m_x, bfc_sum;
  logic                pair_two, pos_ok;

  assign rem_cur  = m_len_q - pos_q.bfc;
  assign bw_cur   = width_for(mode_q, rem_cur);
  assign pfr_x    = {1'b0, pos_q.pfr};
  assign k_x      = {1'b0, k_len_q};
  assign m_x      = {1'b0, m_len_q};
  assign pair_two = (pfr_x + (DIM_BITS+1)'(1)) < k_x;
  assign bfc_sum  = {1'b0, pos_q.bfc} + (DIM_BITS+1)'(bw_cur);
  assign pos_ok   = (pos_q.bfc < m_len_q) && (pos_q.pfr < k_len_q) &&
                    (pos_q.cib < bw_cur) && (!pos_q.rip || pair_two);

  always_comb begin
    pos_d = '0;
    if (!s_axis_tdata[0] && pos_ok) begin
      pos_d    = pos_q;
      pos_d.dc = pos_q.dc + COUNT_BITS'(1);
      if (!pos_q.rip && pair_two) begin
        pos_d.rip = 1'b1;
      end else begin
        pos_d.rip = 1'b0;
        if ((pos_q.cib + BLK_W'(1)) < bw_cur) begin
          pos_d.cib = pos_q.cib + BLK_W'(1);
        end else begin
          pos_d.cib = '0;
          if ((pfr_x + (DIM_BITS+1)'(2)) < k_x) begin
            pos_d.pfr = pos_q.pfr + DIM_BITS'(2);
          end else if (bfc_sum >= m_x) begin
            // Past the final element: back to the first one.
            pos_d = '0;
          end else begin
            pos_d.pfr = '0;
            pos_d.bfc = bfc_sum[DIM_BITS-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept && len_ok) begin
      pos_q <= pos_d;
    end
  end

  // Stage 1: snapshot of the new position.
  pos_t s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= accept && len_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && len_ok) begin
      s1_pos_q <= pos_d;
    end
  end

  // Stage 2: row and column offsets, destination address, final flag.
  logic [DIM_BITS-1:0]  rem2, row2, col2;
  logic [BLK_W-1:0]     bw2;
  logic [DIM_BITS:0]    pfr2_x;
  logic                 pair2, last2;
  logic [DIM_BITS:0]    kr_q, mcol_q;
  logic [ADDR_BITS-1:0] dest2_q;
  logic                 last2_q;

  assign rem2   = m_len_q - s1_pos_q.bfc;
  assign bw2    = width_for(mode_q, rem2);
  assign pfr2_x = {1'b0, s1_pos_q.pfr};
  assign pair2  = (pfr2_x + (DIM_BITS+1)'(1)) < k_x;
  assign row2   = s1_pos_q.pfr + DIM_BITS'(s1_pos_q.rip);
  assign col2   = s1_pos_q.bfc + DIM_BITS'(s1_pos_q.cib);
  assign last2  = (({1'b0, s1_pos_q.bfc} + (DIM_BITS+1)'(bw2)) >= m_x) &&
                  ((s1_pos_q.cib + BLK_W'(1)) == bw2) &&
                  ((pfr2_x + (DIM_BITS+1)'(2)) >= k_x) &&
                  (s1_pos_q.rip == pair2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (rdy2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      kr_q    <= {1'b0, k_off_q} + {1'b0, row2};
      mcol_q  <= {1'b0, m_off_q} + {1'b0, col2};
      dest2_q <= dst_base_q + ADDR_BITS'(s1_pos_q.dc);
      last2_q <= last2;
    end
  end

  // Stage 3: row offset times stride, base plus column.
  logic [PROD_W-1:0]    prod_q;
  logic [ADDR_BITS-1:0] bcol_q, dest3_q;
  logic                 last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (rdy3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      prod_q  <= PROD_W'(kr_q) * PROD_W'(stride_q);
      bcol_q  <= src_base_q + ADDR_BITS'(mcol_q);
      dest3_q <= dest2_q;
      last3_q <= last2_q;
    end
  end

  // Output register: final source address sum.
  logic [ADDR_BITS-1:0] src_out_q, dest_out_q;
  logic                 last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_out) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && s3_v_q) begin
      src_out_q  <= bcol_q + ADDR_BITS'(prod_q);
      dest_out_q <= dest3_q;
      last_out_q <= last3_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({dest_out_q, src_out_q});
  assign m_axis_tlast  = last_out_q;

endmodule

### hdl/gppag_checker.sv
// ----------------------------------------------------------------------------
// GEMM panel pack address generator port checker
// Concurrent checks on the stream ports of the address generator, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module gppag_checker #(
  parameter int unsigned OUT_W = 96
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its addresses and final flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Requests are only refused when every stage is full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request refused with room in the pipeline");

  // A result taken frees room, so a request can be taken in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("request refused while a result is taken");

endmodule

bind gemm_panel_pack_address_gen_top gppag_checker #(.OUT_W(OUT_W)) u_gppag_checker (.*);

### tb/gemm_panel_pack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel packing address checker
// Watches the configuration port and both streams of the panel packing
// address generator. It keeps its own copy of the registers and of the walk
// position, works out the address pair that each accepted request should
// produce, and compares every result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module gemm_panel_pack_checker
  import gppag_pkg::*;
#(
  parameter int unsigned DIM_BITS  = 16,
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned CFG_W     = 48,
  parameter int unsigned OUT_W     = 96
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [0] restart
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OUT_W-1:0]     m_axis_tdata,  // source_address, dest_address
  input  logic                 m_axis_tlast,  // last element
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic                 last;
  } addr_pair_t;

  // Register copy.
  logic [DIM_BITS-1:0]  k_len;
  logic [DIM_BITS-1:0]  m_len;
  logic [DIM_BITS-1:0]  stride;
  logic [DIM_BITS-1:0]  k_off;
  logic [DIM_BITS-1:0]  m_off;
  logic                 six_wide;
  logic [ADDR_BITS-1:0] src_base;
  logic [ADDR_BITS-1:0] dst_base;

  // Walk position.
  logic [DIM_BITS-1:0]   blk_col;
  logic [BLK_W-1:0]      blk_w;
  logic [DIM_BITS-1:0]   pair_row;
  logic [BLK_W-1:0]      col_in_blk;
  logic                  row_in_pr;
  logic [COUNT_BITS-1:0] pack_idx;

  addr_pair_t expected_pairs[$];
  int         fails;
  int         checked_count;

  // Width of the block that starts with the given number of columns left.
  function automatic logic [BLK_W-1:0] width_of(input logic [DIM_BITS-1:0] left);
    if (six_wide && left >= BW_SIX) return BW_SIX;
    if (left >= BW_FOUR) return BW_FOUR;
    if (left >= BW_TWO) return BW_TWO;
    return BW_ONE;
  endfunction

  // Rows in the current pair: one for an odd final row.
  function automatic int unsigned pair_rows();
    return (32'(pair_row) + 1 < 32'(k_len)) ? 2 : 1;
  endfunction

  function automatic void restart_walk();
    blk_col    = '0;
    pair_row   = '0;
    col_in_blk = '0;
    row_in_pr  = 1'b0;
    pack_idx   = '0;
    blk_w      = width_of(m_len);
  endfunction

  // The held position may no longer fit after the registers were changed.
  function automatic bit walk_fits();
    if (blk_col >= m_len || pair_row >= k_len) return 1'b0;
    if (col_in_blk >= width_of(m_len - blk_col)) return 1'b0;
    if (32'(row_in_pr) >= pair_rows()) return 1'b0;
    return 1'b1;
  endfunction

  // Move on by one element: row in pair, column in block, row pair, block.
  function automatic void step_walk();
    blk_w    = width_of(m_len - blk_col);
    pack_idx = pack_idx + 1'b1;
    if (32'(row_in_pr) + 1 < pair_rows()) begin
      row_in_pr = 1'b1;
      return;
    end
    row_in_pr = 1'b0;
    if (32'(col_in_blk) + 1 < 32'(blk_w)) begin
      col_in_blk = col_in_blk + 1'b1;
      return;
    end
    col_in_blk = '0;
    if (32'(pair_row) + 2 < 32'(k_len)) begin
      pair_row = pair_row + 2'd2;
      return;
    end
    pair_row = '0;
    if (32'(blk_col) + 32'(blk_w) >= 32'(m_len)) begin
      restart_walk();
      return;
    end
    blk_col = blk_col + blk_w;
    blk_w   = width_of(m_len - blk_col);
  endfunction

  // Expected address pair for one accepted request, if it makes one.
  function automatic void predict_pair(input logic restart);
    logic [63:0] row;
    logic [63:0] col;
    logic [63:0] src;
    addr_pair_t  pair;
    if (k_len == '0 || m_len == '0) return;
    if (restart || !walk_fits()) restart_walk();
    else step_walk();
    blk_w = width_of(m_len - blk_col);
    row   = 64'(pair_row) + 64'(row_in_pr);
    col   = 64'(blk_col) + 64'(col_in_blk);
    src   = 64'(src_base) + (64'(k_off) + row) * 64'(stride) + 64'(m_off) + col;
    pair.src_addr = src[ADDR_BITS-1:0];
    pair.dst_addr = dst_base + ADDR_BITS'(pack_idx);
    pair.last     = (32'(blk_col) + 32'(blk_w) >= 32'(m_len)) &&
                    (32'(col_in_blk) + 1 == 32'(blk_w)) &&
                    (32'(pair_row) + 2 >= 32'(k_len)) &&
                    (32'(row_in_pr) + 1 == pair_rows());
    expected_pairs.push_back(pair);
  endfunction

  function automatic void write_reg_copy(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] value);
    case (cfg_reg_e'(idx))
      REG_K_LENGTH:    k_len    = value[DIM_BITS-1:0];
      REG_M_LENGTH:    m_len    = value[DIM_BITS-1:0];
      REG_ROW_STRIDE:  stride   = value[DIM_BITS-1:0];
      REG_K_OFFSET:    k_off    = value[DIM_BITS-1:0];
      REG_M_OFFSET:    m_off    = value[DIM_BITS-1:0];
      REG_BLOCK_MODE:  six_wide = value[0];
      REG_SOURCE_BASE: src_base = value[ADDR_BITS-1:0];
      REG_DEST_BASE:   dst_base = value[ADDR_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Compare one result with the oldest expected pair, field by field.
  function automatic void check_pair();
    addr_pair_t want;
    logic [ADDR_BITS-1:0] got_src;
    logic [ADDR_BITS-1:0] got_dst;
    got_src = m_axis_tdata[ADDR_BITS-1:0];
    got_dst = m_axis_tdata[2*ADDR_BITS-1:ADDR_BITS];
    if (expected_pairs.size() == 0) begin
      $error("unexpected result: source_address %h dest_address %h last %b",
             got_src, got_dst, m_axis_tlast);
      fails++;
      return;
    end
    want = expected_pairs.pop_front();
    checked_count++;
    if (got_src !== want.src_addr) begin
      $error("source_address: expected %h, actual %h", want.src_addr, got_src);
      fails++;
    end
    if (got_dst !== want.dst_addr) begin
      $error("dest_address: expected %h, actual %h", want.dst_addr, got_dst);
      fails++;
    end
    if (m_axis_tlast !== want.last) begin
      $error("last: expected %b, actual %b", want.last, m_axis_tlast);
      fails++;
    end
  endfunction

  // Track configuration, requests and results at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_len    = 1;
      m_len    = 1;
      stride   = 1;
      k_off    = '0;
      m_off    = '0;
      six_wide = 1'b0;
      src_base = '0;
      dst_base = '0;
      restart_walk();
      expected_pairs.delete();
      fails         = 0;
      checked_count = 0;
    end else begin
      if (cfg_we_i) write_reg_copy(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) predict_pair(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) check_pair();
    end
    fail_count_o <= fails;
    pending_o    <= expected_pairs.size();
    checked_o    <= checked_count;
  end

endmodule

### tb/tb_gemm_panel_pack_address_gen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel packing address generator testbench
// Programs a series of panel shapes, strides, offsets and bases, including
// the extremes and empty panels, and sends restart and advance requests in
// random bursts against a randomly stalling receiver. A separate checker
// predicts every address pair and reports mismatches.
// ----------------------------------------------------------------------------
module tb_gemm_panel_pack_address_gen_top;
  import gppag_pkg::*;

  localparam int unsigned DIM_BITS    = 16;
  localparam int unsigned ADDR_BITS   = 48;
  localparam int unsigned CFG_W       = (ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS;
  localparam int unsigned OUT_W       = ((2 * ADDR_BITS + 7) / 8) * 8;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned PIPE_SETTLE = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [DIM_BITS-1:0]  DIM_MAX  = '1;
  localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

  typedef struct {
    logic [DIM_BITS-1:0]  k_len;
    logic [DIM_BITS-1:0]  m_len;
    logic [DIM_BITS-1:0]  stride;
    logic [DIM_BITS-1:0]  k_off;
    logic [DIM_BITS-1:0]  m_off;
    logic                 six_wide;
    logic [ADDR_BITS-1:0] src_base;
    logic [ADDR_BITS-1:0] dst_base;
  } panel_cfg_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;

  int         fail_count;
  int         pending;
  int         checked;
  int         cycle_count    = 0;
  int         hold_off_asks  = 0;
  int         burst_left     = 0;
  int         addr_requests  = 0;
  int         empty_requests = 0;
  int         settings_used  = 0;
  panel_cfg_t active_cfg;

  always #2 clk_i = ~clk_i;

  gemm_panel_pack_address_gen_top #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  gemm_panel_pack_checker #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS),
    .CFG_W     (CFG_W),
    .OUT_W     (OUT_W)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: changes its stall style every so often, and holds off for a
  // long stretch whenever the stimulus asks for it.
  initial begin : ready_pattern
    int unsigned style;
    int unsigned span;
    int unsigned hold_left;
    int          hold_offs_given;
    style           = 0;
    span            = 0;
    hold_left       = 0;
    hold_offs_given = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_asks != hold_offs_given) begin
        hold_offs_given++;
        hold_left = 400;
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(20, 300);
      end
      span--;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= (span % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // One request, sent in bursts with random gaps between them.
  task automatic send_request(input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    if (active_cfg.k_len != '0 && active_cfg.m_len != '0) addr_requests++;
    else empty_requests++;
  endtask

  // Wait for every expected result, then let any empty-panel request leave
  // the pipeline before the registers change.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Program a whole panel description; the walk position is kept.
  task automatic program_panel(input panel_cfg_t c);
    wait_idle();
    write_reg(REG_K_LENGTH,    CFG_W'(c.k_len));
    write_reg(REG_M_LENGTH,    CFG_W'(c.m_len));
    write_reg(REG_ROW_STRIDE,  CFG_W'(c.stride));
    write_reg(REG_K_OFFSET,    CFG_W'(c.k_off));
    write_reg(REG_M_OFFSET,    CFG_W'(c.m_off));
    write_reg(REG_BLOCK_MODE,  CFG_W'(c.six_wide));
    write_reg(REG_SOURCE_BASE, CFG_W'(c.src_base));
    write_reg(REG_DEST_BASE,   CFG_W'(c.dst_base));
    cfg_we_i   <= 1'b0;
    active_cfg = c;
    settings_used++;
  endtask

  function automatic panel_cfg_t make_panel(input logic [DIM_BITS-1:0] k_len,
                                            input logic [DIM_BITS-1:0] m_len,
                                            input logic [DIM_BITS-1:0] stride,
                                            input logic [DIM_BITS-1:0] k_off,
                                            input logic [DIM_BITS-1:0] m_off,
                                            input logic six_wide,
                                            input logic [ADDR_BITS-1:0] src_base,
                                            input logic [ADDR_BITS-1:0] dst_base);
    panel_cfg_t c;
    c.k_len    = k_len;
    c.m_len    = m_len;
    c.stride   = stride;
    c.k_off    = k_off;
    c.m_off    = m_off;
    c.six_wide = six_wide;
    c.src_base = src_base;
    c.dst_base = dst_base;
    return c;
  endfunction

  // A dimension: mostly small so that walks finish and wrap, now and then
  // empty, full scale or anything in range.
  function automatic logic [DIM_BITS-1:0] pick_length(input int unsigned small_max);
    case ($urandom_range(0, 29))
      0:       return '0;
      1:       return DIM_MAX;
      2:       return DIM_BITS'($urandom_range(1, DIM_MAX));
      default: return DIM_BITS'($urandom_range(1, small_max));
    endcase
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_dim_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 1;
      2:       return DIM_MAX;
      default: return DIM_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ADDR_MAX;
      default: return ADDR_BITS'({$urandom, $urandom});
    endcase
  endfunction

  function automatic panel_cfg_t random_panel();
    return make_panel(pick_length(9), pick_length(16), pick_dim_value(),
                      pick_dim_value(), pick_dim_value(), $urandom_range(0, 1),
                      pick_base(), pick_base());
  endfunction

  // Stimulus and verdict.
  initial begin
    panel_cfg_t  c;
    int unsigned burst;
    bit          hold_off_done;
    active_cfg    = make_panel(1, 1, 1, 0, 0, 1'b0, '0, '0);
    hold_off_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-element panel straight after reset: restart, then wrap round.
    send_request(1'b1);
    send_request(1'b0);

    // Empty panels in K and in M: requests are swallowed.
    program_panel(make_panel(0, 3, 5, 1, 2, 1'b0, 48'h100, 48'h200));
    send_request(1'b1);
    send_request(1'b0);
    program_panel(make_panel(2, 0, 5, 1, 2, 1'b1, 48'h100, 48'h200));
    send_request(1'b0);
    send_request(1'b1);

    // Extreme stride, offsets and bases; a two-then-one block walk that wraps.
    program_panel(make_panel(1, 3, DIM_MAX, DIM_MAX, DIM_MAX, 1'b1, ADDR_MAX, ADDR_MAX));
    send_request(1'b1);
    repeat (4) send_request(1'b0);

    // Part way through a six-wide block, then the panel narrows under the
    // walk, so the next advance starts again from the first element.
    c = make_panel(5, 9, 100, 0, 0, 1'b1, '0, 48'h1000);
    program_panel(c);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    c.m_len = 2;
    program_panel(c);
    repeat (3) send_request(1'b0);

    // Full-scale dimensions.
    program_panel(make_panel(DIM_MAX, DIM_MAX, DIM_MAX, 0, 0, 1'b0, '0, '0));
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // Random panels; advances mostly, with the odd restart.
    while (addr_requests < ITEM_TARGET) begin
      c = random_panel();
      program_panel(c);
      burst = $urandom_range(10, 80);
      if (!hold_off_done && c.k_len != '0 && c.m_len != '0) begin
        hold_off_done = 1'b1;
        hold_off_asks++;
        burst = 150;
      end
      repeat (burst) send_request($urandom_range(0, 19) == 0);
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d address requests and %0d empty-panel requests over %0d settings.",
             addr_requests, empty_requests, settings_used);
    $display("Compared %0d address pairs, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
